FILE: hdl/bbc_pkg.sv
// Package for the bracket balance checker: transaction payload types,
// status codes, bracket type codes and character constants.
// No dependencies.
package bbc_pkg;

    localparam int ErrPosWidth = 16;

    typedef logic [1:0] status_t;
    typedef logic [1:0] bracket_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_CLOSE = 2'd1;
    localparam status_t ST_UNCLOSED  = 2'd2;
    localparam status_t ST_OVERFLOW  = 2'd3;

    localparam bracket_t BR_ROUND  = 2'd0;
    localparam bracket_t BR_CURLY  = 2'd1;
    localparam bracket_t BR_SQUARE = 2'd2;

    localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;  // (
    localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;  // )
    localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
    localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }
    localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    typedef struct packed {
        status_t                status;
        logic [ErrPosWidth-1:0] error_position;
        bracket_t               open_type;
    } out_item_t;

endpackage

FILE: hdl/bracket_balance_checker_unit.sv
// Bracket balance checker: one character per cycle when ready, one result per expression.
// The result of an expression is registered as its last character is taken.
// The stack top is kept in a register and the entry below it is prefetched from the stack
// memory every cycle, so a push or pop never waits; s_ready falls while the skid is full.
// A result register plus a skid register let input continue while a result is stalled.
// Reset (aresetn low, synchronous) clears the counters, error state and handshake; the
// stack memory is not cleared, since only entries below the count are ever read.
module bracket_balance_checker_unit #(
    parameter int STACK_DEPTH   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bbc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bbc_pkg::out_item_t m_data
);
    import bbc_pkg::*;

    localparam int CountWidth = $clog2(STACK_DEPTH + 1);
    localparam int AddrWidth  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    bracket_t stack_mem [STACK_DEPTH];

    logic [CountWidth-1:0]    count_reg, count_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] err_idx_reg, err_idx_next;
    status_t                  err_reg, err_next;
    bracket_t                 top_reg, top_next;
    bracket_t                 below_reg;

    logic                 push_en, pop_en;
    logic [AddrWidth-1:0] wr_addr, rd_addr;
    logic                 is_open, is_close;
    bracket_t             open_kind, close_kind;
    logic                 accept;

    out_item_t            res;
    logic                 res_valid;
    logic [ErrPosWidth-1:0] err_pos_ext;

    out_item_t out_reg, skid_reg;
    logic      out_valid_reg, skid_valid_reg;

    assign accept  = s_valid && s_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        is_open   = 1'b1;
        open_kind = BR_ROUND;
        unique case (s_data.char_code)
            CH_ROUND_OPEN:  open_kind = BR_ROUND;
            CH_CURLY_OPEN:  open_kind = BR_CURLY;
            CH_SQUARE_OPEN: open_kind = BR_SQUARE;
            default:        is_open = 1'b0;
        endcase
        is_close   = 1'b1;
        close_kind = BR_ROUND;
        unique case (s_data.char_code)
            CH_ROUND_CLOSE:  close_kind = BR_ROUND;
            CH_CURLY_CLOSE:  close_kind = BR_CURLY;
            CH_SQUARE_CLOSE: close_kind = BR_SQUARE;
            default:         is_close = 1'b0;
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        err_idx_next = err_idx_reg;
        err_next     = err_reg;
        push_en      = 1'b0;
        pop_en       = 1'b0;
        if (accept && err_reg == ST_OK) begin
            if (is_open) begin
                if (count_reg >= CountWidth'(STACK_DEPTH)) begin
                    err_next     = ST_OVERFLOW;
                    err_idx_next = pos_reg;
                end else begin
                    push_en = 1'b1;
                end
            end else if (is_close) begin
                if (count_reg == '0 || top_reg != close_kind) begin
                    err_next     = ST_BAD_CLOSE;
                    err_idx_next = pos_reg;
                end else begin
                    pop_en = 1'b1;
                end
            end
            // The position sticks at its all-ones value.
            if (pos_reg != '1) begin
                pos_next = pos_reg + 1'b1;
            end
        end
        if (push_en) begin
            count_next = count_reg + 1'b1;
        end else if (pop_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        if (push_en) begin
            top_next = open_kind;
        end else if (pop_en) begin
            top_next = below_reg;
        end else begin
            top_next = top_reg;
        end
    end

    generate
        if (POSITION_BITS >= ErrPosWidth) begin : g_pos_trunc
            assign err_pos_ext = err_idx_next[ErrPosWidth-1:0];
        end else begin : g_pos_ext
            assign err_pos_ext = {{(ErrPosWidth - POSITION_BITS){1'b0}}, err_idx_next};
        end
    endgenerate

    always_comb begin
        res_valid = accept && s_data.last;
        res.status         = ST_OK;
        res.error_position = '0;
        res.open_type      = BR_ROUND;
        if (err_next != ST_OK) begin
            res.status         = err_next;
            res.error_position = err_pos_ext;
        end else if (count_next != '0) begin
            res.status    = ST_UNCLOSED;
            res.open_type = top_next;
        end
    end

    // Keep the entry just below the new top prefetched; the push writes the
    // slot above the current top, so it never collides with this read.
    assign wr_addr = count_reg[AddrWidth-1:0];
    assign rd_addr = (count_next >= CountWidth'(2))
                   ? AddrWidth'(count_next - CountWidth'(2)) : '0;

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[wr_addr] <= open_kind;
        end
        below_reg <= stack_mem[rd_addr];
        top_reg   <= top_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pos_reg     <= '0;
            err_idx_reg <= '0;
            err_reg     <= ST_OK;
        end else if (res_valid) begin
            count_reg   <= '0;
            pos_reg     <= '0;
            err_idx_reg <= '0;
            err_reg     <= ST_OK;
        end else begin
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            err_idx_reg <= err_idx_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_reg       <= res;
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule
